// ===== rtl/touch_key_press_repeat_defines.svh =====
// Assertion helpers for the RTL, used by touch_key_press_repeat.sv.
`ifndef TOUCH_KEY_PRESS_REPEAT_DEFINES_SVH
`define TOUCH_KEY_PRESS_REPEAT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TKPR_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TKPR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tkpr_pkg.sv =====
package tkpr_pkg;

    localparam int NUM_KEYS    = 4;
    localparam int KEY_W       = $clog2(NUM_KEYS);
    localparam int COUNT_W     = 13;
    localparam int CALIB_SHIFT = 2;
    localparam int SUM_W       = COUNT_W + CALIB_SHIFT;
    localparam int SEEN_W      = (CALIB_SHIFT > 0) ? CALIB_SHIFT : 1;
    localparam int MS_W        = 16;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(4096);
    // seen counter value at which the last sample of a calibration block arrives
    localparam logic [SEEN_W-1:0]  SEEN_LAST   = SEEN_W'((1 << CALIB_SHIFT) - 1);

    localparam logic [COUNT_W-1:0] THRESHOLD_RST = COUNT_W'(50);
    localparam logic [NUM_KEYS-1:0] MASK_RST     = NUM_KEYS'(3);
    localparam logic [MS_W-1:0]    FIRST_RST     = MS_W'(600);
    localparam logic [MS_W-1:0]    NEXT_RST      = MS_W'(200);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TOUCH_THRESHOLD = 2'd0,
        REG_REPEAT_MASK     = 2'd1,
        REG_FIRST_REPEAT_MS = 2'd2,
        REG_NEXT_REPEAT_MS  = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        REQ_CALIB   = 1'b0,
        REQ_MEASURE = 1'b1
    } req_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  touch_threshold;
        logic [NUM_KEYS-1:0] repeat_mask;
        logic [MS_W-1:0]     first_repeat_ms;
        logic [MS_W-1:0]     next_repeat_ms;
    } cfg_t;

endpackage

// ===== rtl/tkpr_cfg_regs.sv =====
module tkpr_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tkpr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [tkpr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output tkpr_pkg::cfg_t                  cfg
);

    tkpr_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.touch_threshold <= tkpr_pkg::THRESHOLD_RST;
            cfg_reg.repeat_mask     <= tkpr_pkg::MASK_RST;
            cfg_reg.first_repeat_ms <= tkpr_pkg::FIRST_RST;
            cfg_reg.next_repeat_ms  <= tkpr_pkg::NEXT_RST;
        end else if (cfg_valid) begin
            case (tkpr_pkg::cfg_idx_t'(cfg_addr))
                tkpr_pkg::REG_TOUCH_THRESHOLD: begin
                    cfg_reg.touch_threshold <= cfg_wdata[tkpr_pkg::COUNT_W-1:0];
                end
                tkpr_pkg::REG_REPEAT_MASK: begin
                    cfg_reg.repeat_mask <= cfg_wdata[tkpr_pkg::NUM_KEYS-1:0];
                end
                tkpr_pkg::REG_FIRST_REPEAT_MS: begin
                    cfg_reg.first_repeat_ms <= cfg_wdata[tkpr_pkg::MS_W-1:0];
                end
                tkpr_pkg::REG_NEXT_REPEAT_MS: begin
                    cfg_reg.next_repeat_ms <= cfg_wdata[tkpr_pkg::MS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/touch_key_press_repeat.sv =====
// Four-key capacitive touch front end. Each beat on the s_ channel carries one
// charge-transfer count for one key and a millisecond timestamp, and gives
// exactly one beat on the m_ channel. Calibration beats (req_type 0) average
// four counts into the key's baseline; measurement beats (req_type 1) flag a
// touch when the count falls more than touch_threshold below the baseline,
// report a press on the rising edge, and for keys enabled in repeat_mask give
// repeat events after first_repeat_ms and then every next_repeat_ms. A beat
// passes from s_ to m_ through the input register, then the result register; a
// new beat is taken every cycle, and s_ready drops only while both stages
// hold beats and m_ready is low. Configuration writes are taken every cycle
// and must only be issued while no beat is in flight.
`include "touch_key_press_repeat_defines.svh"

module touch_key_press_repeat (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_req_type,
    input  logic [1:0]                      s_key_index,
    input  logic [12:0]                     s_sample_count,
    input  logic [15:0]                     s_now_ms,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_out_key,
    output logic                            m_press_event,
    output logic                            m_repeat_event,
    output logic                            m_key_down,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tkpr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [tkpr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    tkpr_pkg::cfg_t cfg;

    tkpr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // input stage
    logic                              in_valid_reg;
    logic                              in_type_reg;
    logic [tkpr_pkg::KEY_W-1:0]        in_key_reg;
    logic [tkpr_pkg::COUNT_W-1:0]      in_count_reg;
    logic [tkpr_pkg::MS_W-1:0]         in_now_reg;

    // result stage
    logic                              m_valid_reg;
    logic [tkpr_pkg::KEY_W-1:0]        m_key_reg;
    logic                              m_press_reg;
    logic                              m_repeat_reg;
    logic                              m_down_reg;

    // per-key state
    logic [tkpr_pkg::COUNT_W-1:0] baseline_reg   [tkpr_pkg::NUM_KEYS];
    logic [tkpr_pkg::SUM_W-1:0]   calib_sum_reg  [tkpr_pkg::NUM_KEYS];
    logic [tkpr_pkg::SEEN_W-1:0]  calib_seen_reg [tkpr_pkg::NUM_KEYS];
    logic [tkpr_pkg::NUM_KEYS-1:0] held_reg;
    logic [tkpr_pkg::MS_W-1:0]    rep_start_reg  [tkpr_pkg::NUM_KEYS];
    logic [tkpr_pkg::NUM_KEYS-1:0] fast_reg;

    logic                         advance;

    logic [tkpr_pkg::COUNT_W-1:0] baseline_next;
    logic [tkpr_pkg::SUM_W-1:0]   calib_sum_next;
    logic [tkpr_pkg::SEEN_W-1:0]  calib_seen_next;
    logic                         held_next;
    logic [tkpr_pkg::MS_W-1:0]    rep_start_next;
    logic                         fast_next;
    logic                         press_next;
    logic                         repeat_next;
    logic                         down_next;

    logic [tkpr_pkg::COUNT_W-1:0] cnt_sat;
    logic [tkpr_pkg::SUM_W-1:0]   calib_total;
    logic [tkpr_pkg::COUNT_W-1:0] drop;
    logic                         touched;
    logic                         may_rep;
    logic [tkpr_pkg::MS_W-1:0]    delay;
    logic [tkpr_pkg::MS_W-1:0]    elapsed;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign m_valid        = m_valid_reg;
    assign m_out_key      = m_key_reg;
    assign m_press_event  = m_press_reg;
    assign m_repeat_event = m_repeat_reg;
    assign m_key_down     = m_down_reg;

    always_comb begin
        cnt_sat = (in_count_reg > tkpr_pkg::COUNT_LIMIT) ? tkpr_pkg::COUNT_LIMIT
                                                          : in_count_reg;
        calib_total = calib_sum_reg[in_key_reg] + tkpr_pkg::SUM_W'(cnt_sat);
        drop        = baseline_reg[in_key_reg] - cnt_sat;
        touched     = (baseline_reg[in_key_reg] > cnt_sat) &&
                      (drop > cfg.touch_threshold);
        may_rep     = cfg.repeat_mask[in_key_reg];

        baseline_next   = baseline_reg[in_key_reg];
        calib_sum_next  = calib_sum_reg[in_key_reg];
        calib_seen_next = calib_seen_reg[in_key_reg];
        held_next       = held_reg[in_key_reg];
        rep_start_next  = rep_start_reg[in_key_reg];
        fast_next       = fast_reg[in_key_reg];
        press_next      = 1'b0;
        repeat_next     = 1'b0;
        delay           = cfg.first_repeat_ms;
        elapsed         = '0;

        if (tkpr_pkg::req_t'(in_type_reg) == tkpr_pkg::REQ_CALIB) begin
            if (calib_seen_reg[in_key_reg] == tkpr_pkg::SEEN_LAST) begin
                baseline_next   = tkpr_pkg::COUNT_W'(calib_total >> tkpr_pkg::CALIB_SHIFT);
                calib_sum_next  = '0;
                calib_seen_next = '0;
            end else begin
                calib_sum_next  = calib_total;
                calib_seen_next = calib_seen_reg[in_key_reg] + 1'b1;
            end
        end else begin
            if (touched && !held_reg[in_key_reg]) begin
                held_next  = 1'b1;
                press_next = 1'b1;
                if (may_rep) begin
                    fast_next      = 1'b0;
                    rep_start_next = in_now_reg;
                end
            end else if (!touched && held_reg[in_key_reg]) begin
                held_next = 1'b0;
            end
            // timer values seen here already include a restart on this press
            delay   = fast_next ? cfg.next_repeat_ms : cfg.first_repeat_ms;
            elapsed = in_now_reg - rep_start_next;
            if (may_rep && held_next && (elapsed >= delay)) begin
                rep_start_next = in_now_reg;
                fast_next      = 1'b1;
                repeat_next    = 1'b1;
            end
        end
        down_next = held_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            held_reg     <= '0;
            fast_reg     <= '0;
            for (int i = 0; i < tkpr_pkg::NUM_KEYS; i++) begin
                baseline_reg[i]   <= '0;
                calib_sum_reg[i]  <= '0;
                calib_seen_reg[i] <= '0;
                rep_start_reg[i]  <= '0;
            end
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (advance) begin
                baseline_reg[in_key_reg]   <= baseline_next;
                calib_sum_reg[in_key_reg]  <= calib_sum_next;
                calib_seen_reg[in_key_reg] <= calib_seen_next;
                held_reg[in_key_reg]       <= held_next;
                rep_start_reg[in_key_reg]  <= rep_start_next;
                fast_reg[in_key_reg]       <= fast_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_type_reg  <= s_req_type;
            in_key_reg   <= s_key_index;
            in_count_reg <= s_sample_count;
            in_now_reg   <= s_now_ms;
        end
        if (advance) begin
            m_key_reg    <= in_key_reg;
            m_press_reg  <= press_next;
            m_repeat_reg <= repeat_next;
            m_down_reg   <= down_next;
        end
    end

    `TKPR_ASSERT_NOW(a_press_down, aclk, aresetn, m_valid_reg && m_press_reg,
                     m_down_reg, "press event without key down")
    `TKPR_ASSERT_NOW(a_repeat_down, aclk, aresetn, m_valid_reg && m_repeat_reg,
                     m_down_reg, "repeat event without key down")
    `TKPR_ASSERT_NEXT(a_result_loaded, aclk, aresetn, advance, m_valid_reg,
                      "evaluated beat did not reach the result register")
    `TKPR_ASSERT_NOW(a_empty_ready, aclk, aresetn, !in_valid_reg, s_ready,
                     "empty input stage not ready")
    `TKPR_ASSERT_NEXT(a_press_sets_held, aclk, aresetn, advance && press_next,
                      held_reg[$past(in_key_reg)], "press did not set held state")

endmodule

// ===== dv/tkpr_event_checker.sv =====
`timescale 1ns / 100ps

module tkpr_event_checker (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic                                s_req_type,
    input  logic [1:0]                          s_key_index,
    input  logic [12:0]                         s_sample_count,
    input  logic [15:0]                         s_now_ms,

    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [1:0]                          m_out_key,
    input  logic                                m_press_event,
    input  logic                                m_repeat_event,
    input  logic                                m_key_down,

    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [tkpr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [tkpr_pkg::CFG_DATA_W-1:0]     cfg_wdata,

    output int                                  fail_count,
    output int                                  outstanding
);

    typedef struct packed {
        logic [1:0] key;
        logic       press;
        logic       rep;
        logic       down;
    } key_event_t;

    // shadow copy of the block's registers and per-key state
    logic [tkpr_pkg::COUNT_W-1:0]  touch_thr;
    logic [tkpr_pkg::NUM_KEYS-1:0] rep_enable;
    logic [tkpr_pkg::MS_W-1:0]     first_delay;
    logic [tkpr_pkg::MS_W-1:0]     next_delay;

    logic [tkpr_pkg::COUNT_W-1:0]  base_level [tkpr_pkg::NUM_KEYS];
    logic [tkpr_pkg::SUM_W-1:0]    cal_acc    [tkpr_pkg::NUM_KEYS];
    logic [tkpr_pkg::SEEN_W-1:0]   cal_cnt    [tkpr_pkg::NUM_KEYS];
    logic                          key_held   [tkpr_pkg::NUM_KEYS];
    logic [tkpr_pkg::MS_W-1:0]     rep_mark   [tkpr_pkg::NUM_KEYS];
    logic                          rep_fast   [tkpr_pkg::NUM_KEYS];

    key_event_t expected_events [$];

    function automatic key_event_t predict_key_event(logic kind, logic [1:0] k,
                                                     logic [12:0] raw, logic [15:0] now);
        logic [12:0] cnt;
        logic        touched;
        logic        may_rep;
        logic [15:0] delay;
        logic [15:0] elapsed;
        key_event_t  ev;
        cnt = (raw > tkpr_pkg::COUNT_LIMIT) ? tkpr_pkg::COUNT_LIMIT : raw;
        ev = '0;
        ev.key = k;
        if (int'(k) < tkpr_pkg::NUM_KEYS) begin
            if (tkpr_pkg::req_t'(kind) == tkpr_pkg::REQ_CALIB) begin
                cal_acc[k] = cal_acc[k] + tkpr_pkg::SUM_W'(cnt);
                if (cal_cnt[k] == tkpr_pkg::SEEN_LAST) begin
                    base_level[k] = tkpr_pkg::COUNT_W'(cal_acc[k] >> tkpr_pkg::CALIB_SHIFT);
                    cal_acc[k] = '0;
                    cal_cnt[k] = '0;
                end else begin
                    cal_cnt[k] = cal_cnt[k] + 1'b1;
                end
            end else begin
                touched = (base_level[k] > cnt) && ((base_level[k] - cnt) > touch_thr);
                may_rep = rep_enable[k];
                if (touched && !key_held[k]) begin
                    key_held[k] = 1'b1;
                    if (may_rep) begin
                        rep_fast[k] = 1'b0;
                        rep_mark[k] = now;
                    end
                    ev.press = 1'b1;
                end else if (!touched && key_held[k]) begin
                    key_held[k] = 1'b0;
                end
                if (may_rep && key_held[k]) begin
                    delay   = rep_fast[k] ? next_delay : first_delay;
                    elapsed = now - rep_mark[k];
                    if (elapsed >= delay) begin
                        rep_mark[k] = now;
                        rep_fast[k] = 1'b1;
                        ev.rep = 1'b1;
                    end
                end
            end
            ev.down = key_held[k];
        end
        return ev;
    endfunction

    always @(posedge aclk) begin
        key_event_t exp_ev;
        key_event_t got_ev;
        if (!aresetn) begin
            touch_thr   = tkpr_pkg::THRESHOLD_RST;
            rep_enable  = tkpr_pkg::MASK_RST;
            first_delay = tkpr_pkg::FIRST_RST;
            next_delay  = tkpr_pkg::NEXT_RST;
            for (int i = 0; i < tkpr_pkg::NUM_KEYS; i++) begin
                base_level[i] = '0;
                cal_acc[i]    = '0;
                cal_cnt[i]    = '0;
                key_held[i]   = 1'b0;
                rep_mark[i]   = '0;
                rep_fast[i]   = 1'b0;
            end
            expected_events.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (tkpr_pkg::cfg_idx_t'(cfg_addr))
                    tkpr_pkg::REG_TOUCH_THRESHOLD: touch_thr   = cfg_wdata[12:0];
                    tkpr_pkg::REG_REPEAT_MASK:     rep_enable  = cfg_wdata[3:0];
                    tkpr_pkg::REG_FIRST_REPEAT_MS: first_delay = cfg_wdata;
                    tkpr_pkg::REG_NEXT_REPEAT_MS:  next_delay  = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_events.push_back(predict_key_event(s_req_type, s_key_index,
                                                            s_sample_count, s_now_ms));
            if (m_valid && m_ready) begin
                got_ev = '{m_out_key, m_press_event, m_repeat_event, m_key_down};
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, got key %0d press %0b repeat %0b down %0b",
                             $time, got_ev.key, got_ev.press, got_ev.rep, got_ev.down);
                    fail_count++;
                end else begin
                    exp_ev = expected_events.pop_front();
                    if (got_ev !== exp_ev) begin
                        $display("%0t: result mismatch, expected key %0d press %0b repeat %0b down %0b, got key %0d press %0b repeat %0b down %0b",
                                 $time, exp_ev.key, exp_ev.press, exp_ev.rep, exp_ev.down,
                                 got_ev.key, got_ev.press, got_ev.rep, got_ev.down);
                        fail_count++;
                    end
                end
            end
        end
        outstanding = expected_events.size();
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 150;
    localparam int MAX_GAP        = 40;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    logic                            s_req_type;
    logic [1:0]                      s_key_index;
    logic [12:0]                     s_sample_count;
    logic [15:0]                     s_now_ms;
    logic                            m_valid;
    logic                            m_ready;
    logic [1:0]                      m_out_key;
    logic                            m_press_event;
    logic                            m_repeat_event;
    logic                            m_key_down;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [tkpr_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [tkpr_pkg::CFG_DATA_W-1:0] cfg_wdata;

    int fail_count;
    int outstanding;
    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int quiet_cycles    = 0;

    logic [15:0] clock_ms;
    logic [12:0] key_level   [tkpr_pkg::NUM_KEYS];
    logic        key_touched [tkpr_pkg::NUM_KEYS];

    touch_key_press_repeat dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_key_index    (s_key_index),
        .s_sample_count (s_sample_count),
        .s_now_ms       (s_now_ms),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_key      (m_out_key),
        .m_press_event  (m_press_event),
        .m_repeat_event (m_repeat_event),
        .m_key_down     (m_key_down),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata)
    );

    tkpr_event_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_key_index    (s_key_index),
        .s_sample_count (s_sample_count),
        .s_now_ms       (s_now_ms),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_key      (m_out_key),
        .m_press_event  (m_press_event),
        .m_repeat_event (m_repeat_event),
        .m_key_down     (m_key_down),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // ends the run if no beat moves on any channel for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("touch_key_press_repeat regression: fail");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic push_sample(tkpr_pkg::req_t req, logic [1:0] key, logic [12:0] cnt,
                               logic [15:0] now);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
            gap++;
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_req_type     <= req;
        s_key_index    <= key;
        s_sample_count <= cnt;
        s_now_ms       <= now;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_cfg(tkpr_pkg::cfg_idx_t idx, logic [15:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // stop sending and let every beat in flight come out
    task automatic drain_pipeline();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic logic [12:0] near_level(logic [12:0] lvl);
        int v;
        v = int'(lvl) + $urandom_range(40) - 20;
        if (v < 0)
            v = 0;
        if (v > 4096)
            v = 4096;
        return 13'(v);
    endfunction

    function automatic logic [12:0] pick_level();
        if ($urandom_range(3) == 0)
            return 13'd4096;
        return 13'($urandom_range(4096));
    endfunction

    task automatic run_directed();
        // full-scale baseline on key 0, with counts above the limit saturated
        push_sample(tkpr_pkg::REQ_CALIB, 2'd0, 13'd4096, 16'd10);
        push_sample(tkpr_pkg::REQ_CALIB, 2'd0, 13'd8191, 16'd11);
        push_sample(tkpr_pkg::REQ_CALIB, 2'd0, 13'd4096, 16'd12);
        push_sample(tkpr_pkg::REQ_CALIB, 2'd0, 13'd5000, 16'd13);
        // uncalibrated key never touches
        push_sample(tkpr_pkg::REQ_MEASURE, 2'd2, 13'd0, 16'd20);
        // press, then first repeat at 600 and the next at 200
        push_sample(tkpr_pkg::REQ_MEASURE, 2'd0, 13'd0, 16'd100);
        push_sample(tkpr_pkg::REQ_MEASURE, 2'd0, 13'd0, 16'd699);
        push_sample(tkpr_pkg::REQ_MEASURE, 2'd0, 13'd0, 16'd700);
        push_sample(tkpr_pkg::REQ_MEASURE, 2'd0, 13'd0, 16'd899);
        push_sample(tkpr_pkg::REQ_MEASURE, 2'd0, 13'd0, 16'd900);
        // calibration beat while held keeps the key down
        push_sample(tkpr_pkg::REQ_CALIB, 2'd0, 13'd4096, 16'd901);
        // threshold edge: drop of exactly 50 releases, 51 presses
        push_sample(tkpr_pkg::REQ_MEASURE, 2'd0, 13'd4046, 16'd950);
        push_sample(tkpr_pkg::REQ_MEASURE, 2'd0, 13'd4045, 16'd960);
        push_sample(tkpr_pkg::REQ_MEASURE, 2'd0, 13'd8191, 16'd970);
        // key 3 has repeat disabled
        repeat (4) push_sample(tkpr_pkg::REQ_CALIB, 2'd3, 13'd1000, 16'd980);
        push_sample(tkpr_pkg::REQ_MEASURE, 2'd3, 13'd0, 16'd65500);
        push_sample(tkpr_pkg::REQ_MEASURE, 2'd3, 13'd0, 16'd664);
        // repeat timer across the timestamp wrap
        push_sample(tkpr_pkg::REQ_MEASURE, 2'd0, 13'd0, 16'd65400);
        push_sample(tkpr_pkg::REQ_MEASURE, 2'd0, 13'd0, 16'd464);
    endtask

    task automatic run_phase(int step_max);
        logic [1:0] k;
        int         r;
        for (int i = 0; i < tkpr_pkg::NUM_KEYS; i++) begin
            key_level[i]   = pick_level();
            key_touched[i] = 1'b0;
            repeat (4) begin
                clock_ms = clock_ms + 16'($urandom_range(step_max));
                push_sample(tkpr_pkg::REQ_CALIB, 2'(i), near_level(key_level[i]), clock_ms);
            end
        end
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            clock_ms = clock_ms + 16'($urandom_range(step_max));
            r = $urandom_range(99);
            k = 2'($urandom_range(3));
            if (r < 8) begin
                push_sample(tkpr_pkg::req_t'($urandom_range(1)), k, 13'($urandom_range(8191)),
                            16'($urandom));
            end else if (r < 16) begin
                push_sample(tkpr_pkg::REQ_CALIB, k, near_level(key_level[k]), clock_ms);
            end else begin
                if ($urandom_range(99) < 20)
                    key_touched[k] = ~key_touched[k];
                if (key_touched[k])
                    push_sample(tkpr_pkg::REQ_MEASURE, k,
                                ($urandom_range(3) == 0) ? 13'd0
                                    : 13'($urandom_range(int'(key_level[k]) / 2)),
                                clock_ms);
                else
                    push_sample(tkpr_pkg::REQ_MEASURE, k, near_level(key_level[k]),
                                clock_ms);
            end
        end
    endtask

    task automatic apply_settings(logic [12:0] thr, logic [3:0] mask,
                                  logic [15:0] first_ms, logic [15:0] next_ms);
        drain_pipeline();
        write_cfg(tkpr_pkg::REG_TOUCH_THRESHOLD, 16'(thr));
        write_cfg(tkpr_pkg::REG_REPEAT_MASK, 16'(mask));
        write_cfg(tkpr_pkg::REG_FIRST_REPEAT_MS, first_ms);
        write_cfg(tkpr_pkg::REG_NEXT_REPEAT_MS, next_ms);
    endtask

    initial begin
        int step_max;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_req_type     = tkpr_pkg::REQ_CALIB;
        s_key_index    = '0;
        s_sample_count = '0;
        s_now_ms       = '0;
        cfg_valid      = 1'b0;
        cfg_addr       = tkpr_pkg::REG_TOUCH_THRESHOLD;
        cfg_wdata      = '0;
        clock_ms       = 16'd2000;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        run_directed();

        for (int p = 0; p < NUM_PHASES; p++) begin
            step_max = $urandom_range(20, 200);
            case (p)
                0: ;
                1: begin
                    apply_settings(13'd0, 4'hF, 16'd1, 16'd1);
                    step_max = 5;
                end
                2: apply_settings(13'd4096, 4'h0, 16'd65535, 16'd65535);
                3: apply_settings(13'd100, 4'b1010, 16'd0, 16'd0);
                4: begin
                    apply_settings(13'd4095, 4'hF, 16'd65535, 16'd1);
                    step_max = 2000;
                end
                default: apply_settings(13'($urandom_range(600)), 4'($urandom_range(15)),
                                        16'($urandom_range(1, 800)),
                                        16'($urandom_range(1, 300)));
            endcase
            case (p % 4)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 72; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 72; end
                default: begin sender_idle_pct = 27; stall_pct = 27; end
            endcase
            run_phase(step_max);
        end

        drain_pipeline();
        if (fail_count == 0)
            $display("touch_key_press_repeat regression: pass");
        else
            $display("touch_key_press_repeat regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tkpr_pkg.sv
rtl/tkpr_cfg_regs.sv
rtl/touch_key_press_repeat.sv
dv/tkpr_event_checker.sv
dv/tb_top.sv
